@@ hdl/mandelbrot_escape_time_pixel_defines.svh @@
// assertion macros shared by the pixel engine
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MBET_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbet check failed");

// next-cycle implication, checked outside reset
`define MBET_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbet check failed");

`endif

@@ hdl/mbet_pkg.sv @@
package mbet_pkg;

    // design limits
    localparam int MAX_ITERATIONS = 256;
    localparam int MAX_DIMENSION  = 4096;

    // field and datapath widths
    localparam int COORD_W   = 12;
    localparam int CFG_DIM_W = 13;
    localparam int ADDR_W    = 24;
    localparam int CNT_OUT_W = 9;
    localparam int COLOR_W   = 19;
    localparam int Q_W       = 32;
    localparam int ZOOM_W    = 31;
    localparam int FRAC_W    = 28;
    localparam int PROD_W    = 2 * Q_W;
    localparam int WIDE_W    = PROD_W - FRAC_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int DIFF_W = ((COORD_W + 1 > DIM_W) ? COORD_W + 1 : DIM_W) + 1;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int QUO_W  = MAG_W + FRAC_W;
    localparam int STEP_W = $clog2(QUO_W + 1);
    localparam int CNT_W  = $clog2(MAX_ITERATIONS + 1);

    localparam logic [10:0] COLOR_STEP = 11'h505;
    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_REAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_IMAG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_RADIUS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE    = 3'd6;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]    buffer_address;
        logic [CNT_OUT_W-1:0] iteration_count;
        logic [COLOR_W-1:0]   pixel_color;
    } t_out_item;

    // divider start request and result
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] num_mag;
        logic [DIM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_SCALE_MUL,
        S_SCALE_ADD,
        S_ITER_MUL,
        S_ITER_ADD,
        S_DONE
    } t_state;

endpackage

@@ hdl/mbet_div.sv @@
module mbet_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbet_pkg::t_div_req i_req,
    output mbet_pkg::t_div_rsp o_rsp
);
    import mbet_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DIM_W-1:0]  r_rem;
    logic [DIM_W-1:0]  r_dvsr;
    logic [QUO_W-1:0]  r_shift;

    logic [DIM_W:0]    trial;
    logic [DIM_W:0]    trial_sub;
    logic              trial_ge;

    // one restoring step: bring down the next numerator bit
    always_comb begin
        trial     = {r_rem, r_shift[QUO_W-1]};
        trial_sub = trial - {1'b0, r_dvsr};
        trial_ge  = (trial >= {1'b0, r_dvsr});
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(QUO_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // remainder and numerator/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= '0;
            r_dvsr  <= i_req.divisor;
            r_shift <= {i_req.num_mag, {FRAC_W{1'b0}}};
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem   <= trial_ge ? trial_sub[DIM_W-1:0] : trial[DIM_W-1:0];
            r_shift <= {r_shift[QUO_W-2:0], trial_ge};
        end
    end

    assign o_rsp.done     = r_busy && (r_cnt == '0);
    assign o_rsp.quotient = r_shift;

endmodule

@@ hdl/mbet_cmul.sv @@
module mbet_cmul (
    input  logic                                   i_clk,
    input  logic signed [mbet_pkg::Q_W-1:0]        i_x,
    input  logic signed [mbet_pkg::Q_W-1:0]        i_y,
    output logic signed [mbet_pkg::PROD_W-1:0]     o_xx,
    output logic signed [mbet_pkg::PROD_W-1:0]     o_yy,
    output logic signed [mbet_pkg::PROD_W-1:0]     o_xy
);
    import mbet_pkg::*;

    logic signed [PROD_W-1:0] r_xx;
    logic signed [PROD_W-1:0] r_yy;
    logic signed [PROD_W-1:0] r_xy;

    // squares and cross product, registered
    always_ff @(posedge i_clk) begin
        r_xx <= PROD_W'(i_x) * PROD_W'(i_x);
        r_yy <= PROD_W'(i_y) * PROD_W'(i_y);
        r_xy <= PROD_W'(i_x) * PROD_W'(i_y);
    end

    assign o_xx = r_xx;
    assign o_yy = r_yy;
    assign o_xy = r_xy;

endmodule

@@ hdl/mandelbrot_escape_time_pixel.sv @@
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_in_data  (pixel_x, pixel_y)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (address, count, color)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// coordinate mapping: each axis runs through the 41-step bit-serial divider
// escape loop: each iteration runs S_ITER_MUL then S_ITER_ADD through the shared registered multiplier set
// o_in_ready is high only while idle; one result waits in the output register
// reset is synchronous active low and restores the register defaults
// o_cfg_ready is always high
`include "mandelbrot_escape_time_pixel_defines.svh"

module mandelbrot_escape_time_pixel (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  mbet_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output mbet_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mbet_pkg::Q_W-1:0]               i_cfg_data
);
    import mbet_pkg::*;

    localparam int ADDR_FULL_W = 2 * CFG_DIM_W;
    localparam int CPROD_W     = CNT_W + 11;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] d);
        logic [DIM_W-1:0] res;
        if (d == '0) begin
            res = DIM_W'(1);
        end else if (d > MAX_DIMENSION) begin
            res = DIM_W'(MAX_DIMENSION);
        end else begin
            res = DIM_W'(d);
        end
        return res;
    endfunction

    function automatic logic fits32(input logic signed [WIDE_W-1:0] v);
        return (&v[WIDE_W-1:Q_W-1]) || !(|v[WIDE_W-1:Q_W-1]);
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] res;
        if (fits32(v)) begin
            res = v[Q_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = Q_MIN;
        end else begin
            res = Q_MAX;
        end
        return res;
    endfunction

    // configuration registers
    logic [CFG_DIM_W-1:0]  r_cfg_width;
    logic [CFG_DIM_W-1:0]  r_cfg_height;
    logic [ZOOM_W-1:0]     r_cfg_zoom;
    logic signed [Q_W-1:0] r_cfg_off_re;
    logic signed [Q_W-1:0] r_cfg_off_im;
    logic [Q_W-1:0]        r_cfg_radius;
    logic [CFG_DIM_W-1:0]  r_cfg_stride;

    // sequencer and datapath registers
    t_state                r_state;
    t_state                n_state;
    logic [COORD_W-1:0]    r_px;
    logic [COORD_W-1:0]    r_py;
    logic                  r_sel;
    logic                  r_neg;
    logic signed [Q_W-1:0] r_ratio;
    logic signed [Q_W-1:0] r_cr;
    logic signed [Q_W-1:0] r_ci;
    logic signed [Q_W-1:0] r_zr;
    logic signed [Q_W-1:0] r_zi;
    logic [CNT_W-1:0]      r_count;
    logic                  r_chk;
    logic [ADDR_W-1:0]     r_addr;
    t_out_item             r_out;
    logic                  r_out_valid;

    // sequencer outputs
    logic in_ready;
    logic div_start;
    logic ratio_load;
    logic c_load;
    logic iter_step;
    logic out_load;
    logic mul_map;

    // datapath
    logic [COORD_W-1:0]       cur_p;
    logic [DIM_W-1:0]         cur_d;
    logic signed [Q_W-1:0]    cur_off;
    logic [DIFF_W-1:0]        diff;
    logic [DIFF_W-1:0]        neg_diff;
    logic [MAG_W-1:0]         diff_mag;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;
    logic                     quo_ovf;
    logic signed [Q_W-1:0]    quo_small;
    logic signed [Q_W-1:0]    ratio_next;
    logic signed [Q_W-1:0]    mul_x;
    logic signed [Q_W-1:0]    mul_y;
    logic signed [PROD_W-1:0] p_xx;
    logic signed [PROD_W-1:0] p_yy;
    logic signed [PROD_W-1:0] p_xy;
    logic signed [WIDE_W-1:0] c_wide;
    logic signed [WIDE_W-1:0] nr_wide;
    logic signed [WIDE_W-1:0] ni_wide;
    logic [PROD_W-1:0]        mag_sum;
    logic                     mag_over;
    logic                     z_ovf;
    logic [CNT_W-1:0]         cnt_next;
    logic                     cnt_full;
    logic                     iter_stop;
    logic [ADDR_FULL_W-1:0]   addr_full;
    logic [CPROD_W-1:0]       color_prod;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_DIM_W'(800);
            r_cfg_height <= CFG_DIM_W'(600);
            r_cfg_zoom   <= ZOOM_W'(32'h1000_0000);
            r_cfg_off_re <= '0;
            r_cfg_off_im <= '0;
            r_cfg_radius <= 32'h6400_0000;
            r_cfg_stride <= CFG_DIM_W'(800);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:   r_cfg_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_FRAME_HEIGHT:  r_cfg_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_ZOOM_SCALE:    r_cfg_zoom   <= i_cfg_data[ZOOM_W-1:0];
                CFG_OFFSET_REAL:   r_cfg_off_re <= i_cfg_data;
                CFG_OFFSET_IMAG:   r_cfg_off_im <= i_cfg_data;
                CFG_ESCAPE_RADIUS: r_cfg_radius <= i_cfg_data;
                CFG_ROW_STRIDE:    r_cfg_stride <= i_cfg_data[CFG_DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (div_rsp.done) n_state = S_SCALE_MUL;
            S_SCALE_MUL: n_state = S_SCALE_ADD;
            S_SCALE_ADD: n_state = r_sel ? S_ITER_MUL : S_DIV_START;
            S_ITER_MUL:  n_state = S_ITER_ADD;
            S_ITER_ADD:  n_state = iter_stop ? S_DONE : S_ITER_MUL;
            S_DONE:      if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready   = (r_state == S_IDLE);
        div_start  = (r_state == S_DIV_START);
        ratio_load = (r_state == S_DIV_WAIT) && div_rsp.done;
        mul_map    = (r_state == S_SCALE_MUL);
        c_load     = (r_state == S_SCALE_ADD);
        iter_step  = (r_state == S_ITER_ADD);
        out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    // numerator and divisor of the axis being mapped
    always_comb begin
        cur_p    = r_sel ? r_py : r_px;
        cur_d    = eff_dim(r_sel ? r_cfg_height : r_cfg_width);
        cur_off  = r_sel ? r_cfg_off_im : r_cfg_off_re;
        diff     = DIFF_W'({cur_p, 1'b0}) - DIFF_W'(cur_d);
        neg_diff = ~diff + 1'b1;
        diff_mag = diff[DIFF_W-1] ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0];
    end

    assign div_req.start   = div_start;
    assign div_req.num_mag = diff_mag;
    assign div_req.divisor = cur_d;

    mbet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // signed, saturated ratio from the magnitude quotient
    always_comb begin
        quo_ovf   = |div_rsp.quotient[QUO_W-1:Q_W-1];
        quo_small = {1'b0, div_rsp.quotient[Q_W-2:0]};
        if (r_neg) begin
            ratio_next = quo_ovf ? Q_MIN : -quo_small;
        end else begin
            ratio_next = quo_ovf ? Q_MAX : quo_small;
        end
    end

    // shared multiplier set: ratio * zoom while mapping, z products while iterating
    assign mul_x = mul_map ? r_ratio : r_zr;
    assign mul_y = mul_map ? $signed({1'b0, r_cfg_zoom}) : r_zi;

    mbet_cmul u_cmul (
        .i_clk (i_clk),
        .i_x   (mul_x),
        .i_y   (mul_y),
        .o_xx  (p_xx),
        .o_yy  (p_yy),
        .o_xy  (p_xy)
    );

    // scaled coordinate and one escape step
    always_comb begin
        c_wide   = WIDE_W'($signed(p_xy[PROD_W-1:FRAC_W])) - WIDE_W'(cur_off);
        nr_wide  = WIDE_W'($signed(p_xx[PROD_W-1:FRAC_W]))
                 - WIDE_W'($signed(p_yy[PROD_W-1:FRAC_W])) + WIDE_W'(r_cr);
        ni_wide  = $signed(p_xy[PROD_W-1:FRAC_W-1]) + WIDE_W'(r_ci);
        mag_sum  = $unsigned(p_xx) + $unsigned(p_yy);
        mag_over = r_chk && (mag_sum[PROD_W-1:Q_W] > r_cfg_radius);
        z_ovf    = !fits32(nr_wide) || !fits32(ni_wide);
        cnt_next = r_count + CNT_W'(r_chk);
        cnt_full = (cnt_next == CNT_W'(MAX_ITERATIONS));
        iter_stop = mag_over || cnt_full || z_ovf;
    end

    // address and color
    assign addr_full  = ADDR_FULL_W'(i_in_data.pixel_y) * ADDR_FULL_W'(r_cfg_stride)
                      + ADDR_FULL_W'(i_in_data.pixel_x);
    assign color_prod = CPROD_W'(r_count) * CPROD_W'(COLOR_STEP);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_px   <= i_in_data.pixel_x;
            r_py   <= i_in_data.pixel_y;
            r_sel  <= 1'b0;
            r_addr <= addr_full[ADDR_W-1:0];
        end
        if (div_start) begin
            r_neg <= diff[DIFF_W-1];
        end
        if (ratio_load) begin
            r_ratio <= ratio_next;
        end
        if (c_load) begin
            if (r_sel) begin
                r_ci <= sat32(c_wide);
            end else begin
                r_cr <= sat32(c_wide);
            end
            r_sel   <= 1'b1;
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
            r_chk   <= 1'b0;
        end
        if (iter_step) begin
            if (!mag_over) begin
                r_count <= cnt_next;
            end
            if (!iter_stop) begin
                r_zr  <= nr_wide[Q_W-1:0];
                r_zi  <= ni_wide[Q_W-1:0];
                r_chk <= 1'b1;
            end
        end
        if (out_load) begin
            r_out.buffer_address  <= r_addr;
            r_out.iteration_count <= CNT_OUT_W'(r_count);
            r_out.pixel_color     <= (r_count == CNT_W'(MAX_ITERATIONS)) ? '0
                                     : COLOR_W'(color_prod);
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // checks
    `MBET_ASSERT_NXT(a_accept_starts_map, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DIV_START && !o_in_ready)
    `MBET_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV_WAIT)
    `MBET_ASSERT_IMP(a_count_below_limit, i_clk, i_rst_n, r_state == S_ITER_ADD, r_count < CNT_W'(MAX_ITERATIONS))
    `MBET_ASSERT_NXT(a_result_only_from_done, i_clk, i_rst_n, r_state != S_DONE && !r_out_valid, !r_out_valid)

endmodule
